[hdl/cpu8_pkg.sv]
// ----------------------------------------------------------------------------
// cpu8_pkg: shared types and constants of the 8-bit CPU core
// Opcodes, operation codes, flag positions and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none
package cpu8_pkg;

   localparam int MemDepth = 65536;
   localparam int MemAw    = $clog2(MemDepth);

   typedef enum logic [2:0] {
      OP_EXEC  = 3'd0,
      OP_RESV  = 3'd1,
      OP_IRQV  = 3'd2,
      OP_NMIV  = 3'd3,
      OP_LOAD  = 3'd4,
      OP_READ  = 3'd5,
      OP_SETR  = 3'd6,
      OP_SETPC = 3'd7
   } op_type;

   localparam logic [7:0] OPC_CLC = 8'h18;
   localparam logic [7:0] OPC_SEC = 8'h38;
   localparam logic [7:0] OPC_CLD = 8'hd8;
   localparam logic [7:0] OPC_SED = 8'hf8;
   localparam logic [7:0] OPC_NOP = 8'hea;
   localparam logic [7:0] OPC_JMP = 8'h4c;
   localparam logic [7:0] OPC_ADC = 8'h69;
   localparam logic [7:0] OPC_LDAI = 8'ha9;
   localparam logic [7:0] OPC_LDXI = 8'ha2;
   localparam logic [7:0] OPC_LDYI = 8'ha0;
   localparam logic [7:0] OPC_LDAA = 8'had;
   localparam logic [7:0] OPC_LDXA = 8'hae;
   localparam logic [7:0] OPC_LDYA = 8'hac;
   localparam logic [7:0] OPC_STA = 8'h8d;
   localparam logic [7:0] OPC_STX = 8'h8e;
   localparam logic [7:0] OPC_STY = 8'h8c;
   localparam logic [7:0] OPC_INY = 8'hc8;
   localparam logic [7:0] OPC_DEX = 8'hca;
   localparam logic [7:0] OPC_BNE = 8'hd0;
   localparam logic [7:0] OPC_INC = 8'hee;

   localparam logic [15:0] VEC_RESET = 16'hfffc;
   localparam logic [15:0] VEC_IRQ   = 16'hfffe;
   localparam logic [15:0] VEC_NMI   = 16'hfffa;

   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_D = 3;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   localparam logic REG_START = 1'b0;
   localparam logic REG_END   = 1'b1;

   // Which address the memory port uses this cycle.
   typedef enum logic [2:0] {
      ASEL_PC   = 3'd0,
      ASEL_PC1  = 3'd1,
      ASEL_PC2  = 3'd2,
      ASEL_EA   = 3'd3,
      ASEL_VEC  = 3'd4,
      ASEL_VEC1 = 3'd5,
      ASEL_REQ  = 3'd6
   } asel_type;

   // Where the registered read data lands.
   typedef enum logic [2:0] {
      CAP_NONE = 3'd0,
      CAP_OPC  = 3'd1,
      CAP_B1   = 3'd2,
      CAP_B2   = 3'd3,
      CAP_DATA = 3'd4,
      CAP_VLO  = 3'd5
   } cap_type;

   typedef struct packed {
      logic     take;     // latch the request word
      asel_type asel;
      logic     mem_rd;
      logic     mem_wr_req;  // op load: unguarded write of request data
      cap_type  cap;       // capture read data of previous cycle
      logic     exec;      // commit the instruction
      logic     vec_done;  // commit vector fetch into pc
      logic     misc_done; // commit set/read ops
   } cmd_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] opc;
   } sts_type;

   function automatic logic [1:0] opc_len(input logic [7:0] o);
      logic [1:0] n;
      n = 2'd1;
      case (o)
         OPC_ADC, OPC_LDAI, OPC_LDXI, OPC_LDYI, OPC_BNE: n = 2'd2;
         OPC_JMP, OPC_LDAA, OPC_LDXA, OPC_LDYA, OPC_STA, OPC_STX, OPC_STY,
         OPC_INC: n = 2'd3;
         default: n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic logic opc_mem(input logic [7:0] o);
      logic r;
      r = 1'b0;
      case (o)
         OPC_LDAA, OPC_LDXA, OPC_LDYA, OPC_INC: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/cpu8_ctrl.sv]
// ----------------------------------------------------------------------------
// cpu8_ctrl: sequencing state machine
// Steps each word through fetch, data read, execute or a vector/other op.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu8_ctrl import cpu8_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_F0   = 9'b000000010,
      S_F1   = 9'b000000100,
      S_F2   = 9'b000001000,
      S_F3   = 9'b000010000,
      S_DR   = 9'b000100000,
      S_EX   = 9'b001000000,
      S_V1   = 9'b010000000,
      S_V2   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      done;

   // A new word is taken once the previous result has left or leaves now.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.asel = ASEL_PC;
      cmd.cap  = CAP_NONE;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               state_in = S_F0;
            end
         end
         S_F0: begin
            case (sts.op)
               OP_EXEC: begin
                  cmd.asel = ASEL_PC; cmd.mem_rd = 1'b1; state_in = S_F1;
               end
               OP_RESV, OP_IRQV, OP_NMIV: begin
                  cmd.asel = ASEL_VEC; cmd.mem_rd = 1'b1; state_in = S_V1;
               end
               OP_LOAD: begin
                  cmd.asel = ASEL_REQ; cmd.mem_wr_req = 1'b1;
                  cmd.misc_done = 1'b1; done = 1'b1; state_in = S_IDLE;
               end
               OP_READ: begin
                  cmd.asel = ASEL_REQ; cmd.mem_rd = 1'b1; state_in = S_V2;
               end
               default: begin
                  cmd.misc_done = 1'b1; done = 1'b1; state_in = S_IDLE;
               end
            endcase
         end
         S_F1: begin
            cmd.cap = CAP_OPC; cmd.asel = ASEL_PC1; cmd.mem_rd = 1'b1;
            state_in = S_F2;
         end
         S_F2: begin
            cmd.cap = CAP_B1; cmd.asel = ASEL_PC2; cmd.mem_rd = 1'b1;
            state_in = S_F3;
         end
         S_F3: begin
            cmd.cap = CAP_B2;
            state_in = opc_mem(sts.opc) ? S_DR : S_EX;
         end
         S_DR: begin
            cmd.asel = ASEL_EA; cmd.mem_rd = 1'b1; state_in = S_EX;
         end
         S_EX: begin
            cmd.cap = CAP_DATA; cmd.asel = ASEL_EA; cmd.exec = 1'b1;
            done = 1'b1; state_in = S_IDLE;
         end
         S_V1: begin
            cmd.cap = CAP_VLO; cmd.asel = ASEL_VEC1; cmd.mem_rd = 1'b1;
            state_in = S_V2;
         end
         S_V2: begin
            cmd.cap = CAP_DATA;
            cmd.vec_done  = (sts.op != OP_READ);
            cmd.misc_done = (sts.op == OP_READ);
            done = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[hdl/cpu8_dp.sv]
// ----------------------------------------------------------------------------
// cpu8_dp: registers, memory and ALU
// Holds the architectural state, the byte memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu8_dp import cpu8_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic [1:0]  req_reg_select,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data,
   output logic [15:0]      rsp_pc,
   output logic [7:0]       rsp_acc,
   output logic [7:0]       rsp_index_x,
   output logic [7:0]       rsp_index_y,
   output logic [7:0]       rsp_status,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_unknown_opcode
);

   logic [7:0]  mem [MemDepth];
   logic [7:0]  rdata_ff;

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, p_ff, p_in;
   logic [15:0] start_ff, end_ff;
   op_type      op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic [1:0]  sel_ff;
   logic [7:0]  opc_ff, b1_ff, b2_ff, vlo_ff;
   logic [15:0] ea, vec, maddr;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic        unk;
   logic [8:0]  sum;
   logic [7:0]  nzv;
   logic [7:0]  rd_out;
   logic        in_win;

   assign ea  = {b2_ff, b1_ff};
   assign sts.op  = op_ff;
   assign sts.opc = opc_ff;

   always_comb begin
      case (op_ff)
         OP_IRQV: vec = VEC_IRQ;
         OP_NMIV: vec = VEC_NMI;
         default: vec = VEC_RESET;
      endcase
      case (cmd.asel)
         ASEL_PC1:  maddr = pc_ff + 16'd1;
         ASEL_PC2:  maddr = pc_ff + 16'd2;
         ASEL_EA:   maddr = ea;
         ASEL_VEC:  maddr = vec;
         ASEL_VEC1: maddr = vec + 16'd1;
         ASEL_REQ:  maddr = addr_ff;
         default:   maddr = pc_ff;
      endcase
   end

   assign in_win = (ea >= start_ff) && (ea <= end_ff);

   // Instruction execution, vector commit and set/read/load ops.
   always_comb begin
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; p_in = p_ff;
      wr_en = 1'b0; wr_data = req_data; unk = 1'b0; nzv = 8'd0;
      rd_out = 8'd0;
      sum = {1'b0, a_ff} + {1'b0, b1_ff} + {8'd0, p_ff[FLAG_C]};
      if (cmd.mem_wr_req) begin
         wr_en = 1'b1; wr_data = data_ff;
      end
      if (cmd.exec) begin
         pc_in = pc_ff + {14'd0, opc_len(opc_ff)};
         case (opc_ff)
            OPC_CLC: p_in[FLAG_C] = 1'b0;
            OPC_SEC: p_in[FLAG_C] = 1'b1;
            OPC_CLD: p_in[FLAG_D] = 1'b0;
            OPC_SED: p_in[FLAG_D] = 1'b1;
            OPC_NOP: ;
            OPC_JMP: pc_in = ea;
            OPC_ADC: begin
               nzv = sum[7:0]; a_in = nzv;
               p_in[FLAG_C] = sum[8];
               p_in[FLAG_V] = ~(a_ff[7] ^ b1_ff[7]) & (a_ff[7] ^ nzv[7]);
            end
            OPC_LDAI: begin nzv = b1_ff; a_in = nzv; end
            OPC_LDXI: begin nzv = b1_ff; x_in = nzv; end
            OPC_LDYI: begin nzv = b1_ff; y_in = nzv; end
            OPC_LDAA: begin nzv = rdata_ff; a_in = nzv; end
            OPC_LDXA: begin nzv = rdata_ff; x_in = nzv; end
            OPC_LDYA: begin nzv = rdata_ff; y_in = nzv; end
            OPC_STA: begin wr_en = in_win; wr_data = a_ff; end
            OPC_STX: begin wr_en = in_win; wr_data = x_ff; end
            OPC_STY: begin wr_en = in_win; wr_data = y_ff; end
            OPC_INY: begin nzv = y_ff + 8'd1; y_in = nzv; end
            OPC_DEX: begin nzv = x_ff - 8'd1; x_in = nzv; end
            OPC_BNE: begin
               if (!p_ff[FLAG_Z])
                  pc_in = pc_ff + 16'd2 + {{8{b1_ff[7]}}, b1_ff};
            end
            OPC_INC: begin
               nzv = rdata_ff + 8'd1; wr_en = in_win; wr_data = nzv;
            end
            default: unk = 1'b1;
         endcase
         case (opc_ff)
            OPC_ADC, OPC_LDAI, OPC_LDXI, OPC_LDYI, OPC_LDAA, OPC_LDXA,
            OPC_LDYA, OPC_INY, OPC_DEX, OPC_INC: begin
               p_in[FLAG_N] = nzv[7];
               p_in[FLAG_Z] = (nzv == 8'd0);
            end
            default: ;
         endcase
      end
      if (cmd.vec_done) pc_in = {rdata_ff, vlo_ff};
      if (cmd.misc_done) begin
         case (op_ff)
            OP_READ: rd_out = rdata_ff;
            OP_SETPC: pc_in = addr_ff;
            OP_SETR: begin
               case (sel_ff)
                  2'd0: a_in = data_ff;
                  2'd1: x_in = data_ff;
                  2'd2: y_in = data_ff;
                  default: p_in = data_ff;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rdata_ff <= mem[maddr[MemAw-1:0]];
      if (wr_en) mem[maddr[MemAw-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; a_ff <= '0; x_ff <= '0; y_ff <= '0; p_ff <= '0;
         start_ff <= 16'h0000; end_ff <= 16'hffff;
      end else begin
         pc_ff <= pc_in; a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; p_ff <= p_in;
         if (csr_write && csr_index == REG_START) start_ff <= csr_data;
         if (csr_write && csr_index == REG_END)   end_ff   <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff <= op_type'(req_op); addr_ff <= req_address;
         data_ff <= req_data; sel_ff <= req_reg_select;
      end
      case (cmd.cap)
         CAP_OPC: opc_ff <= rdata_ff;
         CAP_B1:  b1_ff  <= rdata_ff;
         CAP_B2:  b2_ff  <= rdata_ff;
         CAP_VLO: vlo_ff <= rdata_ff;
         default: ;
      endcase
      if (cmd.exec || cmd.vec_done || cmd.misc_done) begin
         rsp_pc <= pc_in; rsp_acc <= a_in; rsp_index_x <= x_in;
         rsp_index_y <= y_in; rsp_status <= p_in;
         rsp_read_data <= rd_out; rsp_unknown_opcode <= unk;
      end
   end

endmodule
`default_nettype wire

[hdl/cpu_8bit_instruction_subset.sv]
// Sequence: execute fetches the opcode and two operand bytes, reads a data byte
// if needed and commits; a vector load fetches both vector bytes into pc.
// Throughput: one word at a time; the single-port byte memory sets the pace.
// Reset: synchronous, active high; clears pc, A, X, Y, status and the window
// registers (start 0, end ffff). Memory contents are not cleared.
// ----------------------------------------------------------------------------
// cpu_8bit_instruction_subset: top level of the 8-bit CPU core
// Joins the sequencing state machine and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_8bit_instruction_subset import cpu8_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic [1:0]  req_reg_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pc,
   output logic [7:0]       rsp_acc,
   output logic [7:0]       rsp_index_x,
   output logic [7:0]       rsp_index_y,
   output logic [7:0]       rsp_status,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_unknown_opcode,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   // The controller only sees the op code and fetched opcode; everything
   // else flows through the datapath under command of the controller.
   cmd_type cmd;
   sts_type sts;

   // The result register in the datapath holds a finished word until it is
   // taken; a new word is accepted in the same cycle the old one leaves.
   cpu8_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   cpu8_dp u_dp (
      .clock, .reset, .cmd, .sts, .req_op, .req_address, .req_data,
      .req_reg_select, .csr_write, .csr_index, .csr_data,
      .rsp_pc, .rsp_acc, .rsp_index_x, .rsp_index_y, .rsp_status,
      .rsp_read_data, .rsp_unknown_opcode
   );

endmodule
`default_nettype wire

[hdl/cpu8_checker.sv]
// ----------------------------------------------------------------------------
// cpu8_checker: port-level checks of the CPU core
// Watches the handshakes and result words of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_unknown_opcode
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result word dropped while stalled");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || !$past(rsp_valid) || $past(rsp_ready))
      else $error("stale result kept across accept");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unknown_opcode |-> rsp_read_data == 8'd0)
      else $error("read data on executed word");

endmodule

bind cpu_8bit_instruction_subset cpu8_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_read_data, .rsp_unknown_opcode
);
`default_nettype wire
